FILE: sv/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg - packed framebuffer pixel access, shared definitions
// Store geometry, field widths, format and operation codes, the request word
// passed from front to back, and the per-format helper functions.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Byte store, split over four byte-wide banks (a pixel spans up to 3 bytes)
  localparam int STORE_BYTES = 16384;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_W      = $clog2(NUM_BANKS);
  localparam int BANK_ROWS   = STORE_BYTES / NUM_BANKS;
  localparam int ROW_W       = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int X_W      = 12;
  localparam int Y_W      = 12;
  localparam int VAL_W    = 24;
  localparam int FMT_W    = 3;
  localparam int LW_W     = 13;
  localparam int PROD_W   = Y_W + LW_W;
  localparam int IDX_W    = PROD_W + 1;
  localparam int BITPOS_W = IDX_W + 5;
  localparam int BYTE_W   = BITPOS_W - 3;
  localparam int WIN_W    = 24;
  localparam int SH_W     = 5;
  localparam int LUM_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LW_W;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd1;
  localparam logic [LW_W-1:0]      LW_RESET         = 13'd320;

  // Pixel formats; codes 6 and 7 fall through to rgb888
  localparam logic [FMT_W-1:0] FMT_MONO1  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_MONO8  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB444 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGB666 = 3'd4;
  localparam logic [FMT_W-1:0] FMT_RGB888 = 3'd5;

  // Operations; code 3 acts as a read
  localparam logic [OP_W-1:0] OP_READ      = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_NAT = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE_RGB = 2'd2;

  // Luminance weights and mono1 threshold
  localparam logic [LUM_W-1:0] LUM_R      = 16'd76;
  localparam logic [LUM_W-1:0] LUM_G      = 16'd150;
  localparam logic [LUM_W-1:0] LUM_B      = 16'd29;
  localparam logic [7:0]       LUM_THRESH = 8'd127;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_FETCH,
    B_MERGE
  } back_state_t;

  // One classified request, ready for the read-modify-write
  typedef struct packed {
    logic                             write;
    logic [FMT_W-1:0]                 fmt;
    logic [VAL_W-1:0]                 native;
    logic                             oor;
    logic [BANK_W-1:0]                a_lo;
    logic [NUM_BANKS-1:0][ROW_W-1:0]  rows;
    logic [SH_W-1:0]                  sh;
  } pfa_req_t;

  function automatic logic [SH_W-1:0] bpp_of(input logic [FMT_W-1:0] fmt);
    logic [SH_W-1:0] n;
    case (fmt)
      FMT_MONO1:  n = 5'd1;
      FMT_MONO8:  n = 5'd8;
      FMT_RGB444: n = 5'd12;
      FMT_RGB565: n = 5'd16;
      FMT_RGB666: n = 5'd18;
      default:    n = 5'd24;
    endcase
    return n;
  endfunction

  function automatic logic [VAL_W-1:0] bpp_mask(input logic [FMT_W-1:0] fmt);
    logic [VAL_W-1:0] m;
    case (fmt)
      FMT_MONO1:  m = 24'h000001;
      FMT_MONO8:  m = 24'h0000ff;
      FMT_RGB444: m = 24'h000fff;
      FMT_RGB565: m = 24'h00ffff;
      FMT_RGB666: m = 24'h03ffff;
      default:    m = 24'hffffff;
    endcase
    return m;
  endfunction

  // Expand a masked native value by left shifts; mono formats by replication
  function automatic logic [VAL_W-1:0] to_rgb888(input logic [FMT_W-1:0] fmt,
                                                 input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] c;
    case (fmt)
      FMT_MONO1:  c = v[0] ? 24'hffffff : 24'h000000;
      FMT_MONO8:  c = {v[7:0], v[7:0], v[7:0]};
      FMT_RGB444: c = {v[11:8], 4'h0, v[7:4], 4'h0, v[3:0], 4'h0};
      FMT_RGB565: c = {v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
      FMT_RGB666: c = {v[17:12], 2'b00, v[11:6], 2'b00, v[5:0], 2'b00};
      default:    c = v;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/pfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_front - request front end
// Three-stage stallable pipeline: row product and luminance sum, pixel index
// and value to store, bit position; then the byte address, bank rows, shift
// and range flag are formed and the request is pushed into the queue.
// ----------------------------------------------------------------------------
module pfa_front import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FMT_W-1:0]  cfg_fmt,
  input  logic [LW_W-1:0]   cfg_lw,
  input  logic              clearing,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [X_W-1:0]    in_x,
  input  logic [Y_W-1:0]    in_y,
  input  logic [VAL_W-1:0]  in_val,
  input  logic              q_full,
  output logic              q_push,
  output pfa_req_t          q_req
);

  logic                s1_v_r, s2_v_r, s3_v_r;
  logic                free1, free2, free3;
  logic                in_accept;
  logic [FMT_W-1:0]    s1_fmt_r, s2_fmt_r, s3_fmt_r;
  logic                s1_wr_r, s2_wr_r, s3_wr_r;
  logic                s1_rgb_r;
  logic [X_W-1:0]      s1_x_r;
  logic [PROD_W-1:0]   s1_prod_r;
  logic [VAL_W-1:0]    s1_val_r;
  logic [LUM_W-1:0]    s1_lum_r;
  logic [IDX_W-1:0]    s2_idx_r;
  logic [VAL_W-1:0]    s2_native_r, s3_native_r;
  logic [BITPOS_W-1:0] s3_bitpos_r;

  logic [LUM_W-1:0]    lum_round;
  logic [7:0]          lum8;
  logic [VAL_W-1:0]    native_nxt;
  logic [BITPOS_W-1:0] bitpos_nxt;
  logic [BITPOS_W-1:0] idx_ext;
  logic [SH_W-1:0]     bpp;
  logic [BITPOS_W:0]   end_bit;
  logic [BYTE_W-1:0]   last_byte;
  logic [BYTE_W-1:0]   byte_addr;
  logic [ROW_W-1:0]    row_base;

  // Stage handshake: a stage loads when it is empty or moves on
  assign free3     = !s3_v_r || !q_full;
  assign free2     = !s2_v_r || free3;
  assign free1     = !s1_v_r || free2;
  assign in_tready = free1 && !clearing;
  assign in_accept = in_tvalid && in_tready;
  assign q_push    = s3_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (free1) s1_v_r <= in_accept;
      if (free2) s2_v_r <= s1_v_r;
      if (free3) s3_v_r <= s2_v_r;
    end
  end

  // Stage 1: row product and weighted colour sum
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_fmt_r  <= cfg_fmt;
      s1_wr_r   <= (in_op == OP_WRITE_NAT) || (in_op == OP_WRITE_RGB);
      s1_rgb_r  <= (in_op == OP_WRITE_RGB);
      s1_x_r    <= in_x;
      s1_val_r  <= in_val;
      s1_prod_r <= PROD_W'(in_y) * PROD_W'(cfg_lw);
      s1_lum_r  <= LUM_W'(in_val[23:16]) * LUM_R + LUM_W'(in_val[15:8]) * LUM_G
                 + LUM_W'(in_val[7:0]) * LUM_B;
    end
  end

  // Divide the luminance sum by 255: exact for sums below 65535
  assign lum_round = s1_lum_r + LUM_W'(1) + (s1_lum_r >> 8);
  assign lum8      = lum_round[15:8];

  // Value to store, already masked to the format
  always_comb begin
    if (s1_rgb_r) begin
      case (s1_fmt_r)
        FMT_MONO1:  native_nxt = {23'd0, (lum8 > LUM_THRESH)};
        FMT_MONO8:  native_nxt = {16'd0, lum8};
        FMT_RGB444: native_nxt = {12'd0, s1_val_r[23:20], s1_val_r[15:12],
                                  s1_val_r[7:4]};
        FMT_RGB565: native_nxt = {8'd0, s1_val_r[23:19], s1_val_r[15:10],
                                  s1_val_r[7:3]};
        FMT_RGB666: native_nxt = {6'd0, s1_val_r[23:18], s1_val_r[15:10],
                                  s1_val_r[7:2]};
        default:    native_nxt = s1_val_r;
      endcase
    end else if (s1_fmt_r == FMT_MONO1) begin
      native_nxt = {23'd0, |s1_val_r};
    end else begin
      native_nxt = s1_val_r & bpp_mask(s1_fmt_r);
    end
  end

  // Stage 2: pixel index and stored value
  always_ff @(posedge clk) begin
    if (free2) begin
      s2_fmt_r    <= s1_fmt_r;
      s2_wr_r     <= s1_wr_r;
      s2_native_r <= native_nxt;
      s2_idx_r    <= IDX_W'(s1_prod_r) + IDX_W'(s1_x_r);
    end
  end

  // Scale the index by the bits per pixel with shifts and adds
  assign idx_ext = BITPOS_W'(s2_idx_r);
  always_comb begin
    case (s2_fmt_r)
      FMT_MONO1:  bitpos_nxt = idx_ext;
      FMT_MONO8:  bitpos_nxt = idx_ext << 3;
      FMT_RGB444: bitpos_nxt = (idx_ext << 3) + (idx_ext << 2);
      FMT_RGB565: bitpos_nxt = idx_ext << 4;
      FMT_RGB666: bitpos_nxt = (idx_ext << 4) + (idx_ext << 1);
      default:    bitpos_nxt = (idx_ext << 4) + (idx_ext << 3);
    endcase
  end

  // Stage 3: bit position
  always_ff @(posedge clk) begin
    if (free3) begin
      s3_fmt_r    <= s2_fmt_r;
      s3_wr_r     <= s2_wr_r;
      s3_native_r <= s2_native_r;
      s3_bitpos_r <= bitpos_nxt;
    end
  end

  // Byte address, range check, bank rows and window shift
  assign bpp       = bpp_of(s3_fmt_r);
  assign end_bit   = {1'b0, s3_bitpos_r} + (BITPOS_W+1)'(bpp) - (BITPOS_W+1)'(1);
  assign last_byte = end_bit[BITPOS_W-1:3];
  assign byte_addr = s3_bitpos_r[BITPOS_W-1:3];
  assign row_base  = byte_addr[ROW_W+BANK_W-1:BANK_W];

  always_comb begin
    q_req        = '0;
    q_req.write  = s3_wr_r;
    q_req.fmt    = s3_fmt_r;
    q_req.native = s3_native_r;
    q_req.oor    = end_bit[BITPOS_W] || (last_byte >= BYTE_W'(STORE_BYTES));
    q_req.a_lo   = byte_addr[BANK_W-1:0];
    q_req.sh     = SH_W'(WIN_W) - SH_W'(s3_bitpos_r[2:0]) - bpp;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (BANK_W'(b) >= byte_addr[BANK_W-1:0]) begin
        q_req.rows[b] = row_base;
      end else begin
        q_req.rows[b] = row_base + ROW_W'(1);
      end
    end
  end

endmodule

FILE: sv/pfa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_queue - request queue
// Short first-in first-out buffer of classified requests, decoupling the
// front pipeline from the read-modify-write back end.
// ----------------------------------------------------------------------------
module pfa_queue import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pfa_req_t push_req,
  output logic     full,
  input  logic     pop,
  output pfa_req_t pop_req,
  output logic     empty
);

  pfa_req_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_req = entry_r[rd_ptr_r];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_req;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/pfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_back - banked byte store and read-modify-write engine
// Clears the four byte banks after reset, then takes one request at a time:
// reads the three bytes under the pixel, merges the new bits in, writes the
// touched bytes back and loads the result into the output register.
// ----------------------------------------------------------------------------
module pfa_back import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pfa_req_t          q_req,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [VAL_W-1:0]  out_native,
  output logic [VAL_W-1:0]  out_rgb,
  output logic              out_oor
);

  back_state_t       state_r, state_nxt;
  logic [ROW_W-1:0]  clr_row_r;
  pfa_req_t          req_r;
  logic              merge_go;
  logic              out_free;
  logic              out_tvalid_r;
  logic [VAL_W-1:0]  out_native_r, out_rgb_r;
  logic              out_oor_r;

  logic [7:0]                 rdata   [NUM_BANKS];
  logic [NUM_BANKS-1:0]       bank_we;
  logic [ROW_W-1:0]           bank_waddr [NUM_BANKS];
  logic [7:0]                 bank_wdata [NUM_BANKS];
  logic [WIN_W-1:0]           win, new_win, wmask, pix_mask;
  logic [VAL_W-1:0]           old_val, res_native;
  logic [2:0]                 byte_en;

  assign out_free = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_row_r == ROW_W'(BANK_ROWS - 1)) state_nxt = B_FETCH;
      B_FETCH: if (!q_empty) state_nxt = B_MERGE;
      B_MERGE: if (out_free) state_nxt = B_FETCH;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    clearing = 1'b0;
    q_pop    = 1'b0;
    merge_go = 1'b0;
    unique case (state_r)
      B_CLEAR: clearing = 1'b1;
      B_FETCH: q_pop    = !q_empty;
      B_MERGE: merge_go = out_free;
      default: clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLEAR;
      clr_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_row_r <= clr_row_r + ROW_W'(1);
    end
  end

  // Hold the request under way
  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_req;
  end

  // Byte banks: one write and one registered read per cycle each
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [7:0] mem [BANK_ROWS];
    logic [7:0] rd_r;
    always_ff @(posedge clk) begin
      if (bank_we[b]) mem[bank_waddr[b]] <= bank_wdata[b];
      if (q_pop) rd_r <= mem[q_req.rows[b]];
    end
    assign rdata[b] = rd_r;
  end

  // Gather the three-byte window, first byte in the top bits
  always_comb begin
    win = '0;
    for (int j = 0; j < 3; j++) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (BANK_W'(req_r.a_lo + BANK_W'(j)) == BANK_W'(b)) begin
          win[WIN_W-1-8*j -: 8] = rdata[b];
        end
      end
    end
  end

  // Merge the pixel bits
  assign pix_mask = bpp_mask(req_r.fmt);
  assign wmask    = pix_mask << req_r.sh;
  assign old_val  = (win >> req_r.sh) & pix_mask;
  assign new_win  = (win & ~wmask) | ((req_r.native << req_r.sh) & wmask);
  assign res_native = req_r.write ? req_r.native : old_val;

  for (genvar j = 0; j < 3; j++) begin : g_ben
    assign byte_en[j] = |wmask[WIN_W-1-8*j -: 8];
  end

  // Bank write ports: zero sweep while clearing, touched bytes otherwise
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_we[b]    = clearing;
      bank_waddr[b] = clearing ? clr_row_r : req_r.rows[b];
      bank_wdata[b] = '0;
      for (int j = 0; j < 3; j++) begin
        if (!clearing && BANK_W'(req_r.a_lo + BANK_W'(j)) == BANK_W'(b)) begin
          bank_wdata[b] = new_win[WIN_W-1-8*j -: 8];
          bank_we[b]    = merge_go && req_r.write && !req_r.oor && byte_en[j];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (merge_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_go) begin
      out_native_r <= req_r.oor ? '0 : res_native;
      out_rgb_r    <= req_r.oor ? '0 : to_rgb888(req_r.fmt, res_native);
      out_oor_r    <= req_r.oor;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_native = out_native_r;
  assign out_rgb    = out_rgb_r;
  assign out_oor    = out_oor_r;

  // A request beyond the store never modifies it
  a_oor_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MERGE && req_r.oor) |-> (bank_we == '0))
    else $error("store written for an out-of-range request");

  // A read leaves the store untouched
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (merge_go && !req_r.write) |-> (bank_we == '0))
    else $error("store written for a read request");

  // No request taken during the clearing sweep
  a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("request popped while clearing");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !merge_go)
    else $error("result overwritten before it was taken");

endmodule

FILE: sv/packed_framebuffer_pixel_access_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_framebuffer_pixel_access_unit - packed framebuffer pixel engine
// Reads and writes single pixels in a packed, byte-addressed frame store.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its 16384-byte store to zero, one row of four
// banks per cycle, and in_tready stays low until the sweep is done;
// configuration writes are taken throughout. From then on the back end takes
// one request at a time: it first reads the four byte banks at once, then,
// once the result register is free, merges the pixel bits, writes back the
// touched bytes and loads the result register, and only then takes the next
// request. A request passes three front stages and a two-word queue before
// that. Pixel format and line width are sampled when a request is accepted;
// change them only while the unit is idle.
// ----------------------------------------------------------------------------
module packed_framebuffer_pixel_access_unit import pfa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [47:0]            in_tdata,   // pos_x[11:0], pos_y[23:12], pixel_value[47:24]
  input  logic [OP_W-1:0]        in_tuser,   // operation[1:0]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,  // native_pixel[23:0], rgb888_pixel[47:24]
  output logic [0:0]             out_tuser,  // out_of_range[0]
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [FMT_W-1:0] fmt_r;
  logic [LW_W-1:0]  lw_r;
  logic             clearing;
  logic             q_full, q_empty, q_push, q_pop;
  pfa_req_t         push_req, pop_req;
  logic [VAL_W-1:0] out_native, out_rgb;
  logic             out_oor;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_MONO1;
      lw_r  <= LW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: fmt_r <= cfg_data[FMT_W-1:0];
        REG_LINE_WIDTH:   lw_r  <= cfg_data[LW_W-1:0];
        default:          fmt_r <= fmt_r;
      endcase
    end
  end

  pfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_fmt   (fmt_r),
    .cfg_lw    (lw_r),
    .clearing  (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_x      (in_tdata[11:0]),
    .in_y      (in_tdata[23:12]),
    .in_val    (in_tdata[47:24]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (push_req)
  );

  pfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  pfa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_req      (pop_req),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_native (out_native),
    .out_rgb    (out_rgb),
    .out_oor    (out_oor)
  );

  // Pack the result word
  assign out_tdata = {out_rgb, out_native};
  assign out_tuser = out_oor;

endmodule
